>>> hdl/efws_pkg.sv
// efws_pkg: shared widths, constants and controller state type for the
// earliest free worker scheduler; no dependencies
`default_nettype none

package efws_pkg;

  localparam int TIME_W          = 63;
  localparam int DUR_W           = 31;
  localparam int WIDX_W          = 6;
  localparam int CFG_W           = 7;
  localparam int DEF_MAX_WORKERS = 64;

  localparam logic [CFG_W-1:0]  CFG_RESET = 7'd64;
  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } ctrl_state_t;

endpackage

`default_nettype wire

>>> hdl/efws_if.sv
// efws_in_if / efws_out_if: valid-ready channels carrying one job word and
// one assignment word; depend on efws_pkg for field widths
`default_nettype none

interface efws_in_if;
  logic                         valid;
  logic                         ready;
  logic [efws_pkg::DUR_W-1:0]   job_duration;

  modport source (output valid, output job_duration, input ready);
  modport sink   (input valid, input job_duration, output ready);
endinterface

interface efws_out_if;
  logic                         valid;
  logic                         ready;
  logic [efws_pkg::WIDX_W-1:0]  worker_index;
  logic [efws_pkg::TIME_W-1:0]  job_start;

  modport source (output valid, output worker_index, output job_start, input ready);
  modport sink   (input valid, input worker_index, input job_start, output ready);
endinterface

`default_nettype wire

>>> hdl/efws_cell.sv
// efws_cell: one worker's free time plus one stage of the running-minimum
// chain; depends on efws_pkg
`default_nettype none

module efws_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [IW-1:0]               tap_idx,
  input  wire logic                        cin_vld,
  input  wire logic [IW-1:0]               cin_idx,
  input  wire logic [efws_pkg::TIME_W-1:0] cin_time,
  output      logic                        cout_vld,
  output      logic [IW-1:0]               cout_idx,
  output      logic [efws_pkg::TIME_W-1:0] cout_time,
  input  wire logic                        upd_en,
  input  wire logic [IW-1:0]               upd_idx,
  input  wire logic [efws_pkg::DUR_W-1:0]  upd_dur
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [efws_pkg::TIME_W-1:0] free_r, free_nxt;
  logic                        vld_r, vld_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic [efws_pkg::TIME_W-1:0] time_r, time_nxt;
  logic [efws_pkg::TIME_W:0]   sum;
  logic                        take_own;

  assign sum      = {1'b0, free_r} + {{(efws_pkg::TIME_W-efws_pkg::DUR_W+1){1'b0}}, upd_dur};
  assign take_own = free_r < cin_time;

  always_comb begin
    free_nxt = free_r;
    if (upd_en && (upd_idx == MY_IDX)) begin
      free_nxt = sum[efws_pkg::TIME_W] ? efws_pkg::TIME_MAX : sum[efws_pkg::TIME_W-1:0];
    end
  end

  // pass the candidate on, keeping it only up to the tap cell
  always_comb begin
    vld_nxt  = cin_vld && (MY_IDX <= tap_idx);
    idx_nxt  = take_own ? MY_IDX : cin_idx;
    time_nxt = take_own ? free_r : cin_time;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      free_r <= free_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    time_r <= time_nxt;
  end

  assign cout_vld  = vld_r;
  assign cout_idx  = idx_r;
  assign cout_time = time_r;

endmodule

`default_nettype wire

>>> hdl/efws_ctrl.sv
// efws_ctrl: job acceptance, scan sequencing, result register and free-time
// update issue; depends on efws_pkg
`default_nettype none

module efws_ctrl #(
  parameter int IW = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [efws_pkg::DUR_W-1:0]  in_dur,
  output      logic                        inject,
  input  wire logic                        tap_vld,
  input  wire logic [IW-1:0]               tap_idx,
  input  wire logic [efws_pkg::TIME_W-1:0] tap_time,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [efws_pkg::WIDX_W-1:0] out_idx,
  output      logic [efws_pkg::TIME_W-1:0] out_time,
  output      logic                        upd_en,
  output      logic [IW-1:0]               upd_idx,
  output      logic [efws_pkg::DUR_W-1:0]  upd_dur
);

  efws_pkg::ctrl_state_t state_r, state_nxt;

  logic [efws_pkg::DUR_W-1:0]  dur_r, dur_nxt;
  logic [IW-1:0]               res_idx_r, res_idx_nxt;
  logic [efws_pkg::TIME_W-1:0] res_time_r, res_time_nxt;
  logic                        ovld_r, ovld_nxt;
  logic [efws_pkg::WIDX_W-1:0] oidx_r, oidx_nxt;
  logic [efws_pkg::TIME_W-1:0] otime_r, otime_nxt;
  logic                        slot_free;
  logic                        load_out;

  assign slot_free = !ovld_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      efws_pkg::S_IDLE: if (in_valid) state_nxt = efws_pkg::S_SCAN;
      efws_pkg::S_SCAN: if (tap_vld)  state_nxt = efws_pkg::S_HOLD;
      efws_pkg::S_HOLD: if (slot_free) state_nxt = efws_pkg::S_IDLE;
      default:          state_nxt = efws_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      efws_pkg::S_IDLE: in_ready = 1'b1;
      efws_pkg::S_SCAN: ;
      efws_pkg::S_HOLD: load_out = slot_free;
      default:          ;
    endcase
  end

  assign inject  = in_ready && in_valid;
  assign upd_en  = load_out;
  assign upd_idx = res_idx_r;
  assign upd_dur = dur_r;

  always_comb begin
    dur_nxt      = inject ? in_dur : dur_r;
    res_idx_nxt  = res_idx_r;
    res_time_nxt = res_time_r;
    if ((state_r == efws_pkg::S_SCAN) && tap_vld) begin
      res_idx_nxt  = tap_idx;
      res_time_nxt = tap_time;
    end
    ovld_nxt  = ovld_r && !out_ready;
    oidx_nxt  = oidx_r;
    otime_nxt = otime_r;
    if (load_out) begin
      ovld_nxt  = 1'b1;
      oidx_nxt  = efws_pkg::WIDX_W'(res_idx_r);
      otime_nxt = res_time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efws_pkg::S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dur_r      <= dur_nxt;
    res_idx_r  <= res_idx_nxt;
    res_time_r <= res_time_nxt;
    oidx_r     <= oidx_nxt;
    otime_r    <= otime_nxt;
  end

  assign out_valid = ovld_r;
  assign out_idx   = oidx_r;
  assign out_time  = otime_r;

endmodule

`default_nettype wire

>>> hdl/earliest_free_worker_scheduler_core.sv
// earliest_free_worker_scheduler_core: top level with the row of worker cells,
// controller and worker count register; depends on efws_pkg, efws_if,
// efws_cell and efws_ctrl
//
// usage
//   in_ch  : one word per job, job_duration; accepted on valid && ready
//   out_ch : one word per job, worker_index and job_start, in job order
//   cfg    : cfg_we writes cfg_data as the active worker count; the user
//            writes it only while idle, the block leaves that unenforced;
//            zero counts as one, counts above MAX_WORKERS saturate
//   a candidate minimum walks the cell row one worker per cycle up to the last
//   active worker; a new job waits until the result enters the output register
//   the finished word sits in an output register; a new job is accepted
//   while it waits, and a later result holds until the register frees
//   reset clears every free time to zero, sets the count to 64 and empties
//   the output register; a stall delays the free-time update and job intake
`default_nettype none

module earliest_free_worker_scheduler_core #(
  parameter int MAX_WORKERS = efws_pkg::DEF_MAX_WORKERS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  efws_in_if.sink                         in_ch,
  efws_out_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [efws_pkg::CFG_W-1:0] cfg_data
);

  localparam int IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CW = $clog2(MAX_WORKERS + 1);

  logic [efws_pkg::CFG_W-1:0] cfg_r, cfg_nxt;
  logic [CW-1:0]              n_cnt;
  logic [IW-1:0]              tap_sel;

  logic                        cvld  [MAX_WORKERS];
  logic [IW-1:0]               cidx  [MAX_WORKERS];
  logic [efws_pkg::TIME_W-1:0] ctime [MAX_WORKERS];

  logic                        inject;
  logic                        upd_en;
  logic [IW-1:0]               upd_idx;
  logic [efws_pkg::DUR_W-1:0]  upd_dur;

  assign cfg_nxt = cfg_we ? cfg_data : cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= efws_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    if (cfg_r == '0) begin
      n_cnt = CW'(1);
    end else if (32'(cfg_r) > MAX_WORKERS) begin
      n_cnt = CW'(MAX_WORKERS);
    end else begin
      n_cnt = CW'(cfg_r);
    end
  end

  assign tap_sel = IW'(n_cnt - CW'(1));

  for (genvar k = 0; k < MAX_WORKERS; k++) begin : g_cell
    if (k == 0) begin : g_head
      efws_cell #(.IDX(k), .IW(IW)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_idx   (tap_sel),
        .cin_vld   (inject),
        .cin_idx   ('0),
        .cin_time  (efws_pkg::TIME_MAX),
        .cout_vld  (cvld[k]),
        .cout_idx  (cidx[k]),
        .cout_time (ctime[k]),
        .upd_en    (upd_en),
        .upd_idx   (upd_idx),
        .upd_dur   (upd_dur)
      );
    end else begin : g_body
      efws_cell #(.IDX(k), .IW(IW)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_idx   (tap_sel),
        .cin_vld   (cvld[k-1]),
        .cin_idx   (cidx[k-1]),
        .cin_time  (ctime[k-1]),
        .cout_vld  (cvld[k]),
        .cout_idx  (cidx[k]),
        .cout_time (ctime[k]),
        .upd_en    (upd_en),
        .upd_idx   (upd_idx),
        .upd_dur   (upd_dur)
      );
    end
  end

  efws_ctrl #(.IW(IW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_dur    (in_ch.job_duration),
    .inject    (inject),
    .tap_vld   (cvld[tap_sel]),
    .tap_idx   (cidx[tap_sel]),
    .tap_time  (ctime[tap_sel]),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_idx   (out_ch.worker_index),
    .out_time  (out_ch.job_start),
    .upd_en    (upd_en),
    .upd_idx   (upd_idx),
    .upd_dur   (upd_dur)
  );

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for earliest_free_worker_scheduler_core, a directed job table
// then random jobs over many worker counts, checked against the table or the in-bench model
// depends on efws_pkg, efws_if and the core rtl

module tb_top;

  import efws_pkg::*;

  localparam int MAX_W        = DEF_MAX_WORKERS;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_JOBS  = 1700;

  typedef logic [DUR_W-1:0]  duration_t;
  typedef logic [TIME_W-1:0] time_val_t;
  typedef logic [WIDX_W-1:0] worker_t;
  typedef logic [CFG_W-1:0]  count_t;

  typedef struct packed {
    worker_t   worker;
    time_val_t start;
  } assignment_t;

  typedef struct packed {
    logic        has_cfg;
    count_t      cfg;
    duration_t   dur;
    logic        typed;
    assignment_t want;
  } job_row_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  count_t cfg_data;

  efws_in_if  job_ch ();
  efws_out_if grant_ch ();

  earliest_free_worker_scheduler_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (job_ch),
    .out_ch   (grant_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // scheduler model state
  time_val_t   worker_free_at [MAX_W];
  count_t      worker_count;
  assignment_t pending_grants [$];
  int          error_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic assignment_t schedule_job(input duration_t d);
    int          n;
    int          best;
    logic [63:0] sum;
    assignment_t a;
    n = worker_count;
    if (n == 0) n = 1;
    if (n > MAX_W) n = MAX_W;
    best = 0;
    for (int j = 1; j < n; j++) begin
      if (worker_free_at[j] < worker_free_at[best]) best = j;
    end
    a.worker = worker_t'(best);
    a.start  = worker_free_at[best];
    sum = {1'b0, worker_free_at[best]} + {33'd0, d};
    worker_free_at[best] = sum[63] ? TIME_MAX : sum[TIME_W-1:0];
    return a;
  endfunction

  task automatic send_job(input duration_t d, input logic typed, input assignment_t want);
    assignment_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      job_ch.valid <= 1'b0;
      @(posedge clk);
    end
    job_ch.valid        <= 1'b1;
    job_ch.job_duration <= d;
    do @(posedge clk); while (!job_ch.ready);
    got = schedule_job(d);
    pending_grants.push_back(typed ? want : got);
  endtask

  task automatic wait_drained();
    job_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic set_workers(input count_t n);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_we       <= 1'b0;
    worker_count = n;
  endtask

  function automatic duration_t next_duration();
    case ($urandom_range(9))
      0, 1, 2: return duration_t'($urandom_range(3));
      3:       return '0;
      4:       return '1;
      5:       return duration_t'(1) << $urandom_range(DUR_W - 1);
      default: return duration_t'($urandom);
    endcase
  endfunction

  function automatic count_t pick_worker_count();
    case ($urandom_range(9))
      0:       return count_t'(0);
      1:       return count_t'(1);
      2:       return count_t'(MAX_W);
      3:       return '1;
      4:       return count_t'($urandom_range(MAX_W + 1, 127));
      default: return count_t'($urandom_range(2, 16));
    endcase
  endfunction

  // result side: random stall, in-order check
  initial begin
    assignment_t exp_a;
    grant_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && grant_ch.valid && grant_ch.ready) begin
        if (pending_grants.size() == 0) begin
          $display("%0t: unexpected word, actual worker %0d start %0d", $time,
                   grant_ch.worker_index, grant_ch.job_start);
          error_count++;
        end else begin
          exp_a = pending_grants.pop_front();
          if (grant_ch.worker_index !== exp_a.worker) begin
            $display("%0t: worker_index mismatch, expected %0d, actual %0d", $time,
                     exp_a.worker, grant_ch.worker_index);
            error_count++;
          end
          if (grant_ch.job_start !== exp_a.start) begin
            $display("%0t: job_start mismatch, expected %0d, actual %0d", $time,
                     exp_a.start, grant_ch.job_start);
            error_count++;
          end
        end
      end
      grant_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    job_row_t directed_jobs [17];
    int       sent;
    int       seg_len;
    directed_jobs = '{
      '{1'b0, 7'd0,   31'd0,          1'b1, '{6'd0, 63'd0}},
      '{1'b0, 7'd0,   31'h7FFFFFFF,   1'b1, '{6'd0, 63'd0}},
      '{1'b0, 7'd0,   31'd5,          1'b1, '{6'd1, 63'd0}},
      '{1'b0, 7'd0,   31'd1,          1'b1, '{6'd2, 63'd0}},
      '{1'b1, 7'd0,   31'd3,          1'b1, '{6'd0, 63'h7FFFFFFF}},
      '{1'b1, 7'd1,   31'd0,          1'b1, '{6'd0, 63'h80000002}},
      '{1'b1, 7'd127, 31'd7,          1'b1, '{6'd3, 63'd0}},
      '{1'b1, 7'd2,   31'd10,         1'b1, '{6'd1, 63'd5}},
      '{1'b1, 7'd65,  31'd2,          1'b1, '{6'd4, 63'd0}},
      '{1'b1, 7'd64,  31'h55555555,   1'b0, '{6'd0, 63'd0}},
      '{1'b0, 7'd0,   31'h2AAAAAAA,   1'b0, '{6'd0, 63'd0}},
      '{1'b0, 7'd0,   31'd0,          1'b0, '{6'd0, 63'd0}},
      '{1'b1, 7'd3,   31'd0,          1'b0, '{6'd0, 63'd0}},
      '{1'b0, 7'd0,   31'h7FFFFFFF,   1'b0, '{6'd0, 63'd0}},
      '{1'b0, 7'd0,   31'd1,          1'b0, '{6'd0, 63'd0}},
      '{1'b1, 7'd63,  31'd9,          1'b0, '{6'd0, 63'd0}},
      '{1'b0, 7'd0,   31'd0,          1'b0, '{6'd0, 63'd0}}
    };
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    job_ch.valid        = 1'b0;
    job_ch.job_duration = '0;
    error_count         = 0;
    worker_count        = CFG_RESET;
    send_idle_pct       = 13;
    recv_idle_pct       = 73;
    foreach (worker_free_at[i]) worker_free_at[i] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_jobs[i]) begin
      if (directed_jobs[i].has_cfg) set_workers(directed_jobs[i].cfg);
      send_job(directed_jobs[i].dur, directed_jobs[i].typed, directed_jobs[i].want);
    end

    // three idle profiles, each a run of worker count segments
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 13 : (p == 1) ? 73 : 0;
      recv_idle_pct = (p == 0) ? 73 : (p == 1) ? 13 : 0;
      sent = 0;
      while (sent < RANDOM_JOBS / 3) begin
        set_workers(pick_worker_count());
        seg_len = $urandom_range(20, 80);
        for (int k = 0; k < seg_len; k++) send_job(next_duration(), 1'b0, '0);
        sent += seg_len;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_grants.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
